### rtl/core/aes_pkg.sv
// AES-256 core package: S-box, inverse S-box and GF(2^8) helpers.
// No dependencies; used by every module of the core.
package aes_pkg;

   localparam int NumRounds = 14;
   localparam int NumKeyRegs = 4;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;
   localparam logic [1:0] CSR_KEY3 = 2'd3;

   localparam logic REQ_ENC = 1'b0;
   localparam logic REQ_DEC = 1'b1;

   typedef logic [127:0] block_type;

   typedef struct packed {
      logic load;     // load input block with initial key add
      logic round;    // perform one round
      logic last;     // round is the final one (no mix)
      logic dec;      // decrypt direction
      logic [3:0] rk_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic key_start;
      logic key_busy;
   } key_stat_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type inv_sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = INV_SBOX[s[8*(r+4*((c+4-r)%4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
         t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
         t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // InvMixColumns as a pre-step (x4 terms) followed by the forward mix
   function automatic block_type inv_mix_columns(input block_type s);
      block_type u;
      logic [7:0] a0, a1, a2, a3, e, o;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         e = xtime(xtime(a0 ^ a2));
         o = xtime(xtime(a1 ^ a3));
         u[32*c +: 8]    = a0 ^ e;
         u[32*c+8 +: 8]  = a1 ^ o;
         u[32*c+16 +: 8] = a2 ^ e;
         u[32*c+24 +: 8] = a3 ^ o;
      end
      return mix_columns(u);
   endfunction

endpackage

### rtl/core/aes_stream_if.sv
// Valid/ready stream interface for the AES-256 core channels.
// Depends on nothing; payload fields follow the request and response items.
interface aes_req_if (input logic clock);
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] block_lo;
   logic [63:0] block_hi;
   modport source (output valid, req_type, block_lo, block_hi, input ready);
   modport sink (input valid, req_type, block_lo, block_hi, output ready);
endinterface

interface aes_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [63:0] out_lo;
   logic [63:0] out_hi;
   modport source (output valid, out_lo, out_hi, input ready);
   modport sink (input valid, out_lo, out_hi, output ready);
endinterface

### rtl/core/aes_key_expand.sv
// Key schedule: expands the key registers into 15 round keys, one word a cycle.
// Depends on aes_pkg.
module aes_key_expand (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [255:0]         key,
   input  logic [3:0]           rd_idx,
   output logic [127:0]         rd_key,
   output logic                 busy
);
   // 15 round keys of four words each; word n sits in key n/4, slot n mod 4
   logic [127:0] rk_ff [15];
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [5:0]  pm1, pm8;
   logic [31:0] prev, back, t, nw;

   always_comb begin
      pm1 = cnt_ff - 6'd1;
      pm8 = cnt_ff - 6'd8;
      prev = rk_ff[pm1[5:2]][{pm1[1:0], 5'd0} +: 32];
      back = rk_ff[pm8[5:2]][{pm8[1:0], 5'd0} +: 32];
      t = prev;
      if (cnt_ff[2:0] == 3'd0) begin
         t = {aes_pkg::SBOX[prev[7:0]], aes_pkg::SBOX[prev[31:24]],
              aes_pkg::SBOX[prev[23:16]], aes_pkg::SBOX[prev[15:8]] ^ rcon_ff};
      end else if (cnt_ff[2:0] == 3'd4) begin
         t = {aes_pkg::SBOX[prev[31:24]], aes_pkg::SBOX[prev[23:16]],
              aes_pkg::SBOX[prev[15:8]], aes_pkg::SBOX[prev[7:0]]};
      end
      nw = back ^ t;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rcon_in = rcon_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 6'd8;
         rcon_in = 8'h01;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff[2:0] == 3'd0) rcon_in = aes_pkg::xtime(rcon_ff);
         if (cnt_ff == 6'd59) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 6'd8;
         rcon_ff <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rcon_ff <= rcon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff[0] <= 128'h0;
         rk_ff[1] <= 128'h0;
      end else if (start) begin
         rk_ff[0] <= key[127:0];
         rk_ff[1] <= key[255:128];
      end else if (busy_ff) begin
         rk_ff[cnt_ff[5:2]][{cnt_ff[1:0], 5'd0} +: 32] <= nw;
      end
   end

   assign rd_key = rk_ff[rd_idx];
   assign busy = busy_ff;
endmodule

### rtl/core/aes_datapath.sv
// Round datapath: state register and one AES round per cycle.
// Depends on aes_pkg; driven by aes_ctrl commands.
module aes_datapath (
   input  logic                   clock,
   input  aes_pkg::dp_cmd_type    cmd,
   input  logic [127:0]           in_block,
   input  logic [127:0]           rkey,
   output logic [127:0]           state
);
   aes_pkg::block_type st_ff, st_in, x, y;

   always_comb begin
      st_in = st_ff;
      if (cmd.dec) begin
         x = aes_pkg::inv_sub_shift(st_ff) ^ rkey;
         y = cmd.last ? x : aes_pkg::inv_mix_columns(x);
      end else begin
         x = aes_pkg::sub_shift(st_ff);
         y = (cmd.last ? x : aes_pkg::mix_columns(x)) ^ rkey;
      end
      if (cmd.load) st_in = in_block ^ rkey;
      else if (cmd.round) st_in = y;
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign state = st_ff;
endmodule

### rtl/core/aes_ctrl.sv
// Round sequencer: handshakes, round counter and round key selection.
// Depends on aes_pkg.
module aes_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_type,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  aes_pkg::key_stat_type kstat,
   output aes_pkg::dp_cmd_type   cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] st_ff, st_in;
   logic [3:0] rnd_ff, rnd_in;
   logic       dec_ff, dec_in;
   logic       acc;

   assign req_ready = (st_ff == ST_IDLE) && !kstat.key_busy && !kstat.key_start;
   assign acc = req_valid && req_ready;
   assign rsp_valid = (st_ff == ST_DONE);

   always_comb begin
      st_in = st_ff;
      rnd_in = rnd_ff;
      dec_in = dec_ff;
      cmd = '0;
      unique case (st_ff)
         ST_IDLE: begin
            cmd.dec = req_type;
            cmd.rk_idx = (req_type == aes_pkg::REQ_DEC) ? 4'd14 : 4'd0;
            if (acc) begin
               cmd.load = 1'b1;
               st_in = ST_RUN;
               rnd_in = 4'd1;
               dec_in = req_type;
            end
         end
         ST_RUN: begin
            cmd.round = 1'b1;
            cmd.dec = dec_ff;
            cmd.last = (rnd_ff == 4'd14);
            cmd.rk_idx = dec_ff ? 4'd14 - rnd_ff : rnd_ff;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'd14) st_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         rnd_ff <= 4'd0;
         dec_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         rnd_ff <= rnd_in;
         dec_ff <= dec_in;
      end
   end
endmodule

### rtl/core/aes256_block_cipher_core.sv
// AES-256 block cipher core: one block per request, encrypt or decrypt.
// Each block is loaded with the initial key add, then goes through the rounds,
// and the result is held until taken; a new request is accepted only after
// that, as the single round unit is shared. After reset and after each key
// register write the key schedule runs, one word a cycle, while requests are
// held off. Reset is synchronous, active high, and loads the all-zero key.
module aes256_block_cipher_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   aes_req_if.sink       req,
   aes_rsp_if.source     rsp
);
   logic [63:0]  key_ff [aes_pkg::NumKeyRegs];
   logic [255:0] key_in;
   logic         kstart_ff;
   logic [127:0] rkey, state;
   logic         kbusy;
   aes_pkg::dp_cmd_type   cmd;
   aes_pkg::key_stat_type kstat;

   // Hold the key registers; restart the schedule in the cycle after a write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aes_pkg::NumKeyRegs; i++) key_ff[i] <= 64'h0;
         kstart_ff <= 1'b0;
      end else begin
         kstart_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               aes_pkg::CSR_KEY0: key_ff[0] <= csr_wdata;
               aes_pkg::CSR_KEY1: key_ff[1] <= csr_wdata;
               aes_pkg::CSR_KEY2: key_ff[2] <= csr_wdata;
               aes_pkg::CSR_KEY3: key_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign key_in = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
   assign kstat.key_start = kstart_ff || csr_we;
   assign kstat.key_busy = kbusy;

   aes_key_expand u_keys (
      .clock  (clock),
      .reset  (reset),
      .start  (kstart_ff),
      .key    (key_in),
      .rd_idx (cmd.rk_idx),
      .rd_key (rkey),
      .busy   (kbusy)
   );

   aes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .kstat     (kstat),
      .cmd       (cmd)
   );

   aes_datapath u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .in_block ({req.block_hi, req.block_lo}),
      .rkey     (rkey),
      .state    (state)
   );

   assign rsp.out_lo = state[63:0];
   assign rsp.out_hi = state[127:64];
endmodule
